// File: sv/ieac_pkg.sv
package ieac_pkg;

  typedef logic [2:0][7:0] rgb_t;

  localparam logic [3:0] INK_COPY   = 4'd0;
  localparam logic [3:0] INK_BLEND  = 4'd1;
  localparam logic [3:0] INK_ADD    = 4'd2;
  localparam logic [3:0] INK_SUB    = 4'd3;
  localparam logic [3:0] INK_INVERT = 4'd4;
  localparam logic [3:0] INK_MONO   = 4'd5;
  localparam logic [3:0] INK_XOR    = 4'd6;
  localparam logic [3:0] INK_AND    = 4'd7;
  localparam logic [3:0] INK_OR     = 4'd8;

  localparam logic [0:0] REG_INK_OP      = 1'd0;
  localparam logic [0:0] REG_BLEND_LEVEL = 1'd1;

  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // quotient bits of the color division, one restoring step per stage
  localparam int DIV_STEPS = 8;

  // x / 255 for x below 65280, exact
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

endpackage

// File: sv/ieac_ink.sv
module ieac_ink (
  input  logic [3:0]    op_i,
  input  ieac_pkg::rgb_t src_i,
  input  ieac_pkg::rgb_t dst_i,
  output ieac_pkg::rgb_t ink_o
);

  always_comb begin
    logic [9:0]  sum;
    logic [19:0] prod;
    logic [8:0]  add;
    logic [7:0]  mono;
    sum  = 10'(src_i[0]) + 10'(src_i[1]) + 10'(src_i[2]);
    // sum / 3 through the reciprocal 683 / 2048
    prod = 20'(sum) * 20'd683;
    mono = prod[18:11];
    for (int i = 0; i < 3; i++) begin
      add = 9'(src_i[i]) + 9'(dst_i[i]);
      unique case (op_i)
        ieac_pkg::INK_ADD:    ink_o[i] = add[8] ? ieac_pkg::CHAN_MAX : add[7:0];
        ieac_pkg::INK_SUB:    ink_o[i] = (dst_i[i] > src_i[i]) ? dst_i[i] - src_i[i] : 8'd0;
        ieac_pkg::INK_INVERT: ink_o[i] = ieac_pkg::CHAN_MAX - src_i[i];
        ieac_pkg::INK_MONO:   ink_o[i] = mono;
        ieac_pkg::INK_XOR:    ink_o[i] = src_i[i] ^ dst_i[i];
        ieac_pkg::INK_AND:    ink_o[i] = src_i[i] & dst_i[i];
        ieac_pkg::INK_OR:     ink_o[i] = src_i[i] | dst_i[i];
        default:              ink_o[i] = src_i[i];
      endcase
    end
  end

endmodule

// File: sv/ink_effect_alpha_compositor_unit.sv
// channel   direction  signals                      word
// s_axis    in         tvalid tready tdata[63:0]    source and destination pixel
// m_axis    out        tvalid tready tdata[31:0]    composited pixel
// cfg       in         cfg_we_i cfg_idx_i cfg_wdata_i  register write, no read-back
//
// one pixel per clock sustained while the output is not stalled; stages in order: ink effect and alpha scale,
// products, numerators and weight, then 8 restoring divide stages (one bit each)
// rst_ni clears all stage valid bits and loads ink_op = copy, blend_level = 255
// each stage holds its word while the one after it is full and stalled, so
// the input keeps taking words as long as any stage down the line is empty
module ink_effect_alpha_compositor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int DIV = ieac_pkg::DIV_STEPS;
  localparam int NST = 3 + DIV;

  // configuration
  logic [3:0] ink_op_q;
  logic [7:0] blend_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ink_op_q      <= ieac_pkg::INK_COPY;
      blend_level_q <= ieac_pkg::CHAN_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ieac_pkg::REG_INK_OP:      ink_op_q      <= cfg_wdata_i[3:0];
        ieac_pkg::REG_BLEND_LEVEL: blend_level_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage handshake: a stage moves when it is empty or the next one moves
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    logic rdy;
    rdy = m_axis_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || rdy;
      rdy   = en[k];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: ink effect, source alpha scaled by the blend level in blend mode
  ieac_pkg::rgb_t src, dst, ink;
  logic [7:0]  sa_in, da_in, sa_eff;
  logic [15:0] sa_prod;

  assign src     = s_axis_tdata[23:0];
  assign sa_in   = s_axis_tdata[31:24];
  assign dst     = s_axis_tdata[55:32];
  assign da_in   = s_axis_tdata[63:56];
  assign sa_prod = 16'(sa_in) * 16'(blend_level_q);
  assign sa_eff  = (ink_op_q == ieac_pkg::INK_BLEND) ? ieac_pkg::div255(sa_prod) : sa_in;

  ieac_ink u_ink (
    .op_i  (ink_op_q),
    .src_i (src),
    .dst_i (dst),
    .ink_o (ink)
  );

  ieac_pkg::rgb_t c1_q, d1_q;
  logic [7:0] sa1_q, da1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c1_q  <= ink;
      d1_q  <= dst;
      sa1_q <= sa_eff;
      da1_q <= da_in;
    end
  end

  // stage 2: color times source alpha, destination alpha times the rest
  logic [2:0][15:0] ps_d, ps2_q;
  logic [15:0] pd_d, pd2_q;
  ieac_pkg::rgb_t d2_q;
  logic [7:0] sa2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) ps_d[i] = 16'(c1_q[i]) * 16'(sa1_q);
    pd_d = 16'(da1_q) * 16'(ieac_pkg::CHAN_MAX - sa1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ps2_q <= ps_d;
      pd2_q <= pd_d;
      d2_q  <= d1_q;
      sa2_q <= sa1_q;
    end
  end

  // stage 3: numerators, weight and result alpha
  logic [2:0][23:0] num_d, num3_q;
  logic [16:0] w_sum;
  logic [15:0] w_d, w3_q;
  logic [7:0]  a3_q;
  logic        z3_q;

  always_comb begin
    logic [24:0] t;
    for (int i = 0; i < 3; i++) begin
      t = (25'(ps2_q[i]) << 8) - 25'(ps2_q[i]) + 25'(24'(d2_q[i]) * 24'(pd2_q));
      num_d[i] = t[23:0];
    end
    w_sum = (17'(sa2_q) << 8) - 17'(sa2_q) + 17'(pd2_q);
    w_d   = w_sum[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      num3_q <= num_d;
      w3_q   <= w_d;
      a3_q   <= ieac_pkg::div255(w_d);
      z3_q   <= (w_d == 16'd0);
    end
  end

  // restoring divide, quotient msb first, one bit per stage
  logic [2:0][23:0] rem_q [DIV];
  logic [2:0][23:0] rem_d [DIV];
  logic [2:0][7:0]  quo_q [DIV];
  logic [2:0][7:0]  quo_d [DIV];
  logic [15:0]      w_q   [DIV];
  logic [7:0]       a_q   [DIV];
  logic             z_q   [DIV];

  always_comb begin
    logic [2:0][23:0] rem_in;
    logic [2:0][7:0]  quo_in;
    logic [15:0]      w_in;
    logic             z_in;
    logic [24:0]      diff;
    logic             bit_ok;
    for (int j = 0; j < DIV; j++) begin
      if (j == 0) begin
        rem_in = num3_q;
        quo_in = '0;
        w_in   = w3_q;
        z_in   = z3_q;
      end else begin
        rem_in = rem_q[j-1];
        quo_in = quo_q[j-1];
        w_in   = w_q[j-1];
        z_in   = z_q[j-1];
      end
      for (int i = 0; i < 3; i++) begin
        diff   = {1'b0, rem_in[i]} - (25'(w_in) << (DIV - 1 - j));
        bit_ok = !diff[24];
        rem_d[j][i] = bit_ok ? diff[23:0] : rem_in[i];
        // zero weight gives zero color
        if (j == DIV - 1 && z_in) quo_d[j][i] = '0;
        else                      quo_d[j][i] = {quo_in[i][6:0], bit_ok};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DIV; j++) begin
      if (en[3+j]) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        w_q[j]   <= (j == 0) ? w3_q : w_q[j-1];
        a_q[j]   <= (j == 0) ? a3_q : a_q[j-1];
        z_q[j]   <= (j == 0) ? z3_q : z_q[j-1];
      end
    end
  end

  assign m_axis_tvalid = v_q[NST-1];
  assign m_axis_tdata  = {a_q[DIV-1], quo_q[DIV-1][2], quo_q[DIV-1][1], quo_q[DIV-1][0]};

endmodule

// File: sv/ieac_checker.sv
module ieac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // nothing comes out while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // an empty or draining output stage lets the whole line move
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with free output");

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

  // input is only refused while the output side holds a word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && !s_axis_tready) |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input refused without output stall");

endmodule

bind ink_effect_alpha_compositor_unit ieac_checker u_ieac_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // out_red, out_green, out_blue, out_alpha
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = ieac_pkg::REG_INK_OP;
  logic [7:0]  cfg_wdata_i = '0;

  // register copies as the block should hold them
  logic [3:0]  ink_sel = ieac_pkg::INK_COPY;
  logic [7:0]  blend_lvl = ieac_pkg::CHAN_MAX;

  logic [63:0] pixel_q[$];
  logic [31:0] composite_q[$];
  string       chan_name[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  bit          src_idle_on = 1'b0;
  bit          sink_stall_on = 1'b0;

  ink_effect_alpha_compositor_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ink effect on the source color, then source over destination
  function automatic logic [31:0] composite_pixel(input logic [3:0] op, input logic [7:0] level,
                                                  input logic [63:0] pix);
    int unsigned s[3];
    int unsigned d[3];
    int unsigned c[3];
    int unsigned sa;
    int unsigned da;
    int unsigned w;
    int unsigned gray;
    logic [31:0] res;
    for (int i = 0; i < 3; i++) begin
      s[i] = 32'(pix[8*i +: 8]);
      d[i] = 32'(pix[32 + 8*i +: 8]);
    end
    sa = 32'(pix[31:24]);
    da = 32'(pix[63:56]);
    if (op == ieac_pkg::INK_BLEND) sa = sa * level / ieac_pkg::CHAN_MAX;
    gray = (s[0] + s[1] + s[2]) / 3;
    for (int i = 0; i < 3; i++) begin
      case (op)
        ieac_pkg::INK_ADD:
          c[i] = (s[i] + d[i] > ieac_pkg::CHAN_MAX) ? ieac_pkg::CHAN_MAX : s[i] + d[i];
        ieac_pkg::INK_SUB:    c[i] = (d[i] > s[i]) ? d[i] - s[i] : 0;
        ieac_pkg::INK_INVERT: c[i] = ieac_pkg::CHAN_MAX - s[i];
        ieac_pkg::INK_MONO:   c[i] = gray;
        ieac_pkg::INK_XOR:    c[i] = s[i] ^ d[i];
        ieac_pkg::INK_AND:    c[i] = s[i] & d[i];
        ieac_pkg::INK_OR:     c[i] = s[i] | d[i];
        default:              c[i] = s[i];
      endcase
    end
    w = sa * ieac_pkg::CHAN_MAX + da * (ieac_pkg::CHAN_MAX - sa);
    res = '0;
    // both alphas zero leaves the whole word zero
    if (w != 0) begin
      for (int i = 0; i < 3; i++)
        res[8*i +: 8] = 8'((c[i] * sa * ieac_pkg::CHAN_MAX
                            + d[i] * da * (ieac_pkg::CHAN_MAX - sa)) / w);
      res[31:24] = 8'(w / ieac_pkg::CHAN_MAX);
    end
    return res;
  endfunction

  function automatic logic [63:0] pack_pixel(input logic [7:0] sr, sg, sb, sa,
                                             input logic [7:0] dr, dg, db, da);
    return {da, db, dg, dr, sa, sb, sg, sr};
  endfunction

  function automatic logic [63:0] random_pixel();
    logic [63:0] p;
    p = {$urandom, $urandom};
    // pull alphas to the ends now and then
    case ($urandom_range(0, 11))
      0: p[31:24] = '0;
      1: p[31:24] = ieac_pkg::CHAN_MAX;
      2: p[63:56] = '0;
      3: p[63:56] = ieac_pkg::CHAN_MAX;
      4: p[63:24] = {8'h00, p[55:32], 8'h00};
      default: ;
    endcase
    return p;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ieac_pkg::REG_INK_OP) ink_sel = val[3:0];
    else blend_lvl = val;
  endtask

  // wait until every pixel has gone in and every composite has come out
  task automatic settle_pipeline();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || composite_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin
        src_idle_on = 1'b0;
        sink_stall_on = 1'b0;
      end
      default: begin
        src_idle_on = 1'($urandom_range(0, 1));
        sink_stall_on = 1'($urandom_range(0, 1));
      end
    endcase
  endtask

  task automatic push_corners();
    pixel_q.push_back(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    pixel_q.push_back(pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    pixel_q.push_back(pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pixel_q.push_back(pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h01, 8'h01, 8'hFF));
    pixel_q.push_back(pack_pixel(8'h10, 8'h20, 8'h30, 8'h80, 8'hF0, 8'hE0, 8'hD0, 8'hC8));
    pixel_q.push_back(pack_pixel(8'hAA, 8'hAA, 8'hAA, 8'hFF, 8'h55, 8'h55, 8'h55, 8'h00));
    pixel_q.push_back(pack_pixel(8'h55, 8'h55, 8'h55, 8'h00, 8'hAA, 8'hAA, 8'hAA, 8'hFF));
    pixel_q.push_back(pack_pixel(8'h80, 8'h7F, 8'h01, 8'h7F, 8'h7F, 8'h80, 8'hFE, 8'h80));
  endtask

  task automatic run_phase(input logic [3:0] op, input logic [7:0] lvl, input int n);
    settle_pipeline();
    // upper nibble of the op write is junk the block must drop
    write_reg(ieac_pkg::REG_INK_OP, {4'($urandom_range(0, 15)), op});
    write_reg(ieac_pkg::REG_BLEND_LEVEL, lvl);
    pick_idling();
    push_corners();
    repeat (n) pixel_q.push_back(random_pixel());
  endtask

  // source side: one word per draw, then a random gap while src_idle_on is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        composite_q.push_back(composite_pixel(ink_sel, blend_lvl, s_axis_tdata));
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the word until taken
      end else if (gap_cnt != 0) begin
        gap_cnt <= gap_cnt - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixel_q.pop_front();
        gap_cnt <= src_idle_on ? $urandom_range(0, 10) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink side: check each word, then stall at random while sink_stall_on is set
  always @(posedge clk_i) begin : sink
    int unsigned nxt;
    logic [31:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      nxt = (stall_cnt != 0) ? stall_cnt - 1 : 0;
      if (m_axis_tvalid && m_axis_tready) begin
        if (composite_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
        end else begin
          want = composite_q.pop_front();
          for (int f = 0; f < 4; f++)
            if (m_axis_tdata[8*f +: 8] !== want[8*f +: 8])
              report_mismatch($sformatf("%s got %0d expected %0d", chan_name[f],
                                        m_axis_tdata[8*f +: 8], want[8*f +: 8]));
        end
        nxt = sink_stall_on ? $urandom_range(0, 10) : 0;
      end
      stall_cnt <= nxt;
      m_axis_tready <= (nxt == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: copy at full level
    pick_idling();
    push_corners();
    pixel_q.push_back(pack_pixel(8'h12, 8'h34, 8'h56, 8'h01, 8'h9A, 8'hBC, 8'hDE, 8'h00));
    pixel_q.push_back(pack_pixel(8'h12, 8'h34, 8'h56, 8'h00, 8'h9A, 8'hBC, 8'hDE, 8'h01));
    pixel_q.push_back(pack_pixel(8'hFE, 8'h01, 8'h7F, 8'hFE, 8'h01, 8'hFE, 8'h80, 8'h01));
    pixel_q.push_back(pack_pixel(8'h00, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h80));

    run_phase(ieac_pkg::INK_ADD, 8'($urandom_range(0, 255)), 35);
    run_phase(ieac_pkg::INK_SUB, 8'($urandom_range(0, 255)), 35);
    run_phase(ieac_pkg::INK_INVERT, 8'($urandom_range(0, 255)), 35);
    run_phase(ieac_pkg::INK_MONO, 8'($urandom_range(0, 255)), 35);
    run_phase(ieac_pkg::INK_XOR, 8'($urandom_range(0, 255)), 35);
    run_phase(ieac_pkg::INK_AND, 8'($urandom_range(0, 255)), 35);
    run_phase(ieac_pkg::INK_OR, 8'($urandom_range(0, 255)), 35);
    run_phase(ieac_pkg::INK_BLEND, 8'h00, 35);
    run_phase(ieac_pkg::INK_BLEND, ieac_pkg::CHAN_MAX, 35);
    run_phase(ieac_pkg::INK_BLEND, 8'h01, 30);
    run_phase(ieac_pkg::INK_BLEND, 8'h80, 30);
    run_phase(ieac_pkg::INK_BLEND, 8'($urandom_range(0, 255)), 40);
    run_phase(ieac_pkg::INK_COPY, 8'($urandom_range(0, 255)), 35);
    // codes past the last effect behave as copy
    for (int k = ieac_pkg::INK_OR + 1; k < (1 << $bits(ink_sel)); k++)
      run_phase(4'(k), 8'($urandom_range(0, 255)), 4);
    repeat (4) run_phase(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 20);

    settle_pipeline();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && composite_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: ink_effect_alpha_compositor_unit.f
sv/ieac_pkg.sv
sv/ieac_ink.sv
sv/ink_effect_alpha_compositor_unit.sv
sv/ieac_checker.sv
tb/testbench.sv
